// ===== design/kus_pkg.sv =====
// Shared command, status and entry definitions for the keyed unique stack.
package kus_pkg;

    localparam int KeyW   = 32;
    localparam int ValW   = 32;
    localparam int CmdW   = 2;
    localparam int StatW  = 3;
    localparam int CountW = 5;

    localparam logic [CmdW-1:0] CMD_PUSH   = 2'd0;
    localparam logic [CmdW-1:0] CMD_POP    = 2'd1;
    localparam logic [CmdW-1:0] CMD_PEEK   = 2'd2;
    localparam logic [CmdW-1:0] CMD_LOOKUP = 2'd3;

    localparam logic [StatW-1:0] STAT_OK    = 3'd0;
    localparam logic [StatW-1:0] STAT_EMPTY = 3'd1;
    localparam logic [StatW-1:0] STAT_DUP   = 3'd2;
    localparam logic [StatW-1:0] STAT_FULL  = 3'd3;
    localparam logic [StatW-1:0] STAT_MISS  = 3'd4;

    typedef struct packed {
        logic signed [KeyW-1:0] key;
        logic signed [ValW-1:0] value;
    } t_entry;

endpackage

// ===== design/kus_mem.sv =====
// Single-port entry store with registered read data.
module kus_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  logic            i_we,
    input  logic [AW-1:0]   i_addr,
    input  kus_pkg::t_entry i_wdata,
    output kus_pkg::t_entry o_rdata
);
    import kus_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/keyed_unique_stack_unit.sv =====
// Top level of the keyed unique stack: command sequencer around the entry store.
//
// Input beats (s_*) carry a command, a key and a value; each beat yields exactly
// one output beat (m_*) with status, key, value and the entry count afterwards.
// Push checks every held entry for the same key before writing; lookup walks the
// held entries from the bottom until the key is found. Both read one entry per
// cycle through the single port of the store and then pass to the final state.
// Pop and peek read the top entry and take it in S_POPR before the final state;
// a refused pop or peek on an empty stack goes straight to the final state.
// One command is in flight at a time; s_tready is high only while idle.
// The result sits in an output register, so the next command is accepted while
// a result still waits; a stalled m_tready holds the command that follows in
// its final cycle until the register is taken.
// A synchronous reset empties the stack at once (count to zero) and drops any
// pending result; the store contents are left as they are and never read
// beyond the count.
module keyed_unique_stack_unit #(
    parameter int DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,  // cmd[1:0], key[33:2], value[65:34], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata   // status[2:0], key_out[34:3], value_out[66:35],
                                  // entry_count[71:67]
);
    import kus_pkg::*;

    localparam int FW = $clog2(DEPTH + 1);
    localparam int AW = $clog2(DEPTH);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_POPR = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0]             r_state, n_state;
    logic [CmdW-1:0]        r_cmd, n_cmd;
    logic signed [KeyW-1:0] r_key, n_key;
    logic signed [ValW-1:0] r_val, n_val;
    logic [FW-1:0]          r_fill, n_fill;
    logic [FW-1:0]          r_idx, n_idx;
    logic                   r_cmp_vld, n_cmp_vld;
    logic [StatW-1:0]       r_res_stat, n_res_stat;
    t_entry                 r_res, n_res;
    logic                   r_out_vld, n_out_vld;
    logic [71:0]            r_out_data, n_out_data;

    logic          mem_en;
    logic          mem_we;
    logic [AW-1:0] mem_addr;
    t_entry        mem_wdata;
    t_entry        mem_rdata;

    logic [FW-1:0]   fill_m1;
    logic [FW+4:0]   cnt_ext;
    logic            key_match;
    t_entry          in_entry;

    kus_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_en    (mem_en),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    assign s_tready  = (r_state == S_IDLE);
    assign m_tvalid  = r_out_vld;
    assign m_tdata   = r_out_data;
    assign fill_m1   = r_fill - 1'b1;
    assign key_match = r_cmp_vld && (mem_rdata.key == r_key);
    assign cnt_ext   = {5'd0, n_fill};
    assign in_entry  = '{key: r_key, value: r_val};

    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_key      = r_key;
        n_val      = r_val;
        n_fill     = r_fill;
        n_idx      = r_idx;
        n_cmp_vld  = r_cmp_vld;
        n_res_stat = r_res_stat;
        n_res      = r_res;
        n_out_vld  = r_out_vld && !m_tready;
        n_out_data = r_out_data;
        mem_en     = 1'b0;
        mem_we     = 1'b0;
        mem_addr   = r_idx[AW-1:0];
        mem_wdata  = in_entry;

        unique case (r_state)
            S_IDLE: begin
                if (s_tvalid) begin
                    n_cmd     = s_tdata[1:0];
                    n_key     = s_tdata[33:2];
                    n_val     = s_tdata[65:34];
                    n_idx     = '0;
                    n_cmp_vld = 1'b0;
                    if (s_tdata[1:0] == CMD_POP || s_tdata[1:0] == CMD_PEEK) begin
                        if (r_fill == '0) begin
                            n_res_stat = STAT_EMPTY;
                            n_res      = '0;
                            n_state    = S_FIN;
                        end else begin
                            mem_en   = 1'b1;
                            mem_addr = fill_m1[AW-1:0];
                            n_state  = S_POPR;
                        end
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                priority if (key_match) begin
                    if (r_cmd == CMD_PUSH) begin
                        n_res_stat = STAT_DUP;
                        n_res      = '0;
                    end else begin
                        n_res_stat = STAT_OK;
                        n_res      = mem_rdata;
                    end
                    n_state = S_FIN;
                end else if (r_idx == r_fill) begin
                    if (r_cmd == CMD_PUSH) begin
                        n_res_stat = (r_fill == FW'(DEPTH)) ? STAT_FULL : STAT_OK;
                    end else begin
                        n_res_stat = STAT_MISS;
                    end
                    n_res   = '0;
                    n_state = S_FIN;
                end else begin
                    mem_en    = 1'b1;
                    mem_addr  = r_idx[AW-1:0];
                    n_idx     = r_idx + 1'b1;
                    n_cmp_vld = 1'b1;
                end
            end
            S_POPR: begin
                n_res_stat = STAT_OK;
                n_res      = mem_rdata;
                n_state    = S_FIN;
            end
            S_FIN: begin
                if (!r_out_vld || m_tready) begin
                    if (r_res_stat == STAT_OK) begin
                        if (r_cmd == CMD_PUSH) begin
                            mem_en   = 1'b1;
                            mem_we   = 1'b1;
                            mem_addr = r_fill[AW-1:0];
                            n_fill   = r_fill + 1'b1;
                        end else if (r_cmd == CMD_POP) begin
                            n_fill = fill_m1;
                        end
                    end
                    n_out_vld  = 1'b1;
                    n_out_data = {cnt_ext[CountW-1:0], r_res.value, r_res.key, r_res_stat};
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_fill    <= '0;
            r_out_vld <= 1'b0;
            r_cmp_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_fill    <= n_fill;
            r_out_vld <= n_out_vld;
            r_cmp_vld <= n_cmp_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_key      <= n_key;
        r_val      <= n_val;
        r_idx      <= n_idx;
        r_res_stat <= n_res_stat;
        r_res      <= n_res;
        r_out_data <= n_out_data;
    end

endmodule

// ===== tb/keyed_unique_stack_unit_test.sv =====
// Self-checking testbench for the keyed unique stack: directed and random command streams.
`timescale 1ns / 1ps

module keyed_unique_stack_unit_test;
    import kus_pkg::*;

    localparam int STACK_DEPTH = 16;
    localparam int SETTLE_CYCLES = 3 * (STACK_DEPTH + 3);
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [StatW-1:0]  status;
        logic [KeyW-1:0]   key_out;
        logic [ValW-1:0]   value_out;
        logic [CountW-1:0] count;
    } t_stack_reply;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;  // cmd[1:0], key[33:2], value[65:34], zero pad
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;       // status[2:0], key_out[34:3], value_out[66:35],
                                // entry_count[71:67]

    logic [KeyW-1:0] held_keys [STACK_DEPTH];
    logic [ValW-1:0] held_values [STACK_DEPTH];
    int              held_count = 0;

    t_stack_reply pending_replies [$];
    int           mismatch_count = 0;
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;
    int           hold_left = 0;
    int           cycle_count = 0;

    keyed_unique_stack_unit #(
        .DEPTH(STACK_DEPTH)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int find_held(input logic [KeyW-1:0] k);
        for (int i = 0; i < held_count; i++) begin
            if (held_keys[i] == k) return i;
        end
        return -1;
    endfunction

    function automatic t_stack_reply apply_stack_op(input logic [CmdW-1:0] op,
                                                     input logic [KeyW-1:0] k,
                                                     input logic [ValW-1:0] v);
        t_stack_reply r;
        int slot;
        r = '0;
        r.status = STAT_OK;
        case (op)
            CMD_PUSH: begin
                if (find_held(k) >= 0) begin
                    r.status = STAT_DUP;
                end else if (held_count >= STACK_DEPTH) begin
                    r.status = STAT_FULL;
                end else begin
                    held_keys[held_count] = k;
                    held_values[held_count] = v;
                    held_count++;
                end
            end
            CMD_POP, CMD_PEEK: begin
                if (held_count == 0) begin
                    r.status = STAT_EMPTY;
                end else begin
                    r.key_out = held_keys[held_count-1];
                    r.value_out = held_values[held_count-1];
                    if (op == CMD_POP) held_count--;
                end
            end
            default: begin
                slot = find_held(k);
                if (slot >= 0) begin
                    r.key_out = held_keys[slot];
                    r.value_out = held_values[slot];
                end else begin
                    r.status = STAT_MISS;
                end
            end
        endcase
        r.count = held_count[CountW-1:0];
        return r;
    endfunction

    function automatic logic [KeyW-1:0] fresh_key();
        logic [KeyW-1:0] k;
        do k = $urandom; while (find_held(k) >= 0);
        return k;
    endfunction

    function automatic logic [KeyW-1:0] some_held_key();
        if (held_count == 0) return $urandom;
        return held_keys[$urandom_range(held_count - 1)];
    endfunction

    // Entered just after a falling edge; returns just after a falling edge.
    task automatic send_op(input logic [CmdW-1:0] op, input logic [KeyW-1:0] k,
                           input logic [ValW-1:0] v);
        int gap;
        gap = 0;
        while (gap < 20 && $urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            s_tdata <= 72'({$urandom, $urandom, $urandom});
            repeat (gap) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {6'b0, v, k, op};
        do @(posedge i_clk); while (!s_tready);
        pending_replies.push_back(apply_stack_op(op, k, v));
        @(negedge i_clk);
    endtask

    task automatic send_random_op(input bit filling);
        int r;
        logic [KeyW-1:0] k;
        r = $urandom_range(99);
        if (r < (filling ? 50 : 18)) begin
            send_op(CMD_PUSH, fresh_key(), $urandom);
        end else if (r < (filling ? 60 : 25)) begin
            send_op(CMD_PUSH, some_held_key(), $urandom);
        end else if (r < (filling ? 72 : 65)) begin
            send_op(CMD_POP, $urandom, $urandom);
        end else if (r < (filling ? 80 : 75)) begin
            send_op(CMD_PEEK, $urandom, $urandom);
        end else if (r < (filling ? 92 : 88)) begin
            send_op(CMD_LOOKUP, some_held_key(), $urandom);
        end else begin
            k = some_held_key();
            if ($urandom_range(1)) k = k ^ (32'd1 << $urandom_range(31));
            else k = $urandom;
            send_op(CMD_LOOKUP, k, $urandom);
        end
    endtask

    task automatic test_empty_stack();
        send_op(CMD_POP, 32'h0, 32'h0);
        send_op(CMD_PEEK, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_op(CMD_LOOKUP, 32'h8000_0000, 32'h0);
    endtask

    task automatic test_field_extremes();
        send_op(CMD_PUSH, 32'h8000_0000, 32'h7FFF_FFFF);
        send_op(CMD_PUSH, 32'h7FFF_FFFF, 32'h8000_0000);
        send_op(CMD_PUSH, 32'h0000_0000, 32'hFFFF_FFFF);
        send_op(CMD_PUSH, 32'h8000_0000, 32'h1234_5678);
        send_op(CMD_LOOKUP, 32'h7FFF_FFFF, 32'h0);
        send_op(CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0);
        send_op(CMD_PEEK, 32'h0, 32'h0);
        send_op(CMD_POP, 32'h0, 32'h0);
    endtask

    task automatic test_full_stack();
        while (held_count < STACK_DEPTH) send_op(CMD_PUSH, fresh_key(), $urandom);
        send_op(CMD_PUSH, fresh_key(), $urandom);
        send_op(CMD_PUSH, held_keys[0], $urandom);
        send_op(CMD_LOOKUP, held_keys[0], 32'h0);
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input int n_items);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < n_items; i++) send_random_op(((i / 48) % 2) == 0);
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_left = 300;
        for (int i = 0; i < 30; i++) send_random_op(1'b1);
    endtask

    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_stack_reply got;
        t_stack_reply want;
        if (i_rst_n && m_tvalid && m_tready) begin
            got = {m_tdata[2:0], m_tdata[34:3], m_tdata[66:35], m_tdata[71:67]};
            if (pending_replies.size() == 0) begin
                $display("%0t: unexpected beat, expected none, actual %h", $time, m_tdata);
                mismatch_count++;
            end else begin
                want = pending_replies.pop_front();
                if (got.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, got.status);
                    mismatch_count++;
                end
                if (got.key_out !== want.key_out) begin
                    $display("%0t: key_out expected %h actual %h",
                             $time, want.key_out, got.key_out);
                    mismatch_count++;
                end
                if (got.value_out !== want.value_out) begin
                    $display("%0t: value_out expected %h actual %h",
                             $time, want.value_out, got.value_out);
                    mismatch_count++;
                end
                if (got.count !== want.count) begin
                    $display("%0t: entry_count expected %0d actual %0d",
                             $time, want.count, got.count);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_empty_stack();
        test_field_extremes();
        test_full_stack();
        test_random_traffic(0, 0, 340);
        test_random_traffic(60, 0, 340);
        test_backpressure();
        test_random_traffic(0, 60, 340);
        test_random_traffic(30, 30, 340);
        test_random_traffic(0, 0, 60);
        s_tvalid <= 1'b0;
        recv_stall_pct = 0;
        while (pending_replies.size() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
